// ===== design/ftrg_pkg.sv =====
package ftrg_pkg;

  // Timestamp bits that take part in the interval; the input field itself is 32 bits.
  localparam int unsigned TimeBits = 32;
  localparam int unsigned InW      = 32;
  localparam int unsigned TimeW    = (TimeBits < InW) ? TimeBits : InW;

  localparam int unsigned SmoothW  = 25;
  localparam int unsigned RungW    = 3;
  localparam int unsigned PctW     = 7;
  localparam int unsigned HoldW    = 7;
  localparam int unsigned ThrW     = 17;
  localparam int unsigned DtW      = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned OutW     = 48;

  // Smoothing arithmetic: keep 0.9, take 0.1, both in Q16, rounded.
  localparam int unsigned DtMax    = 100000;
  localparam int unsigned EmaKeep  = 58982;
  localparam int unsigned EmaTake  = 6554;
  localparam int unsigned EmaRound = 32768;
  localparam int unsigned AccW     = 42;
  localparam int unsigned TakeW    = 34;

  localparam logic [SmoothW-1:0] SmoothReset   = 25'd4275200;
  localparam logic [RungW-1:0]   TopRung       = 3'd4;
  localparam logic [ThrW-1:0]    SlowReset     = 17'd20000;
  localparam logic [ThrW-1:0]    FastReset     = 17'd11500;
  localparam logic [HoldW-1:0]   DownHoldReset = 7'd45;
  localparam logic [HoldW-1:0]   UpHoldReset   = 7'd90;

  typedef enum logic [1:0] {
    ModeAuto   = 2'd0,
    ModeFull   = 2'd1,
    ModeEighty = 2'd2,
    ModeHalf   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode     = 3'd0,
    CfgSlow     = 3'd1,
    CfgFast     = 3'd2,
    CfgDownHold = 3'd3,
    CfgUpHold   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    mode_e            mode;
    logic [ThrW-1:0]  slow;
    logic [ThrW-1:0]  fast;
    logic [HoldW-1:0] down_hold;
    logic [HoldW-1:0] up_hold;
  } cfg_t;

  typedef struct packed {
    logic [RungW-1:0] rung;
    logic             changed;
    logic [HoldW-1:0] hold;
  } gov_t;

  function automatic logic [PctW-1:0] rung_percent(input logic [RungW-1:0] rung);
    logic [PctW-1:0] pct;
    case (rung)
      3'd0:    pct = 7'd40;
      3'd1:    pct = 7'd50;
      3'd2:    pct = 7'd65;
      3'd3:    pct = 7'd80;
      default: pct = 7'd100;
    endcase
    return pct;
  endfunction

endpackage

// ===== design/ftrg_ema.sv =====
module ftrg_ema (
  input  logic [ftrg_pkg::TimeW-1:0]   now_i,
  input  logic [ftrg_pkg::TimeW-1:0]   prev_i,
  input  logic [ftrg_pkg::SmoothW-1:0] smooth_i,
  output logic [ftrg_pkg::SmoothW-1:0] smooth_o
);

  logic [ftrg_pkg::TimeW-1:0] diff;
  logic [ftrg_pkg::DtW-1:0]   dt;
  logic [ftrg_pkg::AccW-1:0]  keep;
  logic [ftrg_pkg::TakeW-1:0] take;
  logic [ftrg_pkg::AccW-1:0]  sum;

  assign diff = now_i - prev_i;

  // A timestamp that goes backwards counts as a zero interval; long gaps saturate.
  always_comb begin
    if (now_i <= prev_i) begin
      dt = '0;
    end else if (diff > ftrg_pkg::TimeW'(ftrg_pkg::DtMax)) begin
      dt = ftrg_pkg::DtW'(ftrg_pkg::DtMax);
    end else begin
      dt = diff[ftrg_pkg::DtW-1:0];
    end
  end

  assign keep = ftrg_pkg::AccW'(smooth_i) * ftrg_pkg::AccW'(ftrg_pkg::EmaKeep);
  assign take = ftrg_pkg::TakeW'(dt) * ftrg_pkg::TakeW'(ftrg_pkg::EmaTake);
  assign sum  = keep + ftrg_pkg::AccW'({take, 8'b0})
              + ftrg_pkg::AccW'(ftrg_pkg::EmaRound);

  // Without a known previous timestamp the smoothed time is left alone.
  assign smooth_o = (prev_i != '0) ? sum[16 +: ftrg_pkg::SmoothW] : smooth_i;

endmodule

// ===== design/ftrg_gov.sv =====
module ftrg_gov (
  input  ftrg_pkg::cfg_t               cfg_i,
  input  logic [ftrg_pkg::RungW-1:0]   rung_i,
  input  logic [ftrg_pkg::HoldW-1:0]   hold_i,
  input  logic [ftrg_pkg::SmoothW-1:0] smooth_i,
  output ftrg_pkg::gov_t               gov_o
);

  logic [ftrg_pkg::SmoothW-1:0] slow_lim;
  logic [ftrg_pkg::SmoothW-1:0] fast_lim;
  logic [ftrg_pkg::RungW-1:0]   target;
  logic [ftrg_pkg::HoldW-1:0]   hold_next;

  assign slow_lim = {cfg_i.slow, 8'b0};
  assign fast_lim = {cfg_i.fast, 8'b0};

  always_comb begin
    target    = rung_i;
    hold_next = hold_i;
    unique case (cfg_i.mode)
      ftrg_pkg::ModeFull:   target = ftrg_pkg::TopRung;
      ftrg_pkg::ModeEighty: target = 3'd3;
      ftrg_pkg::ModeHalf:   target = 3'd1;
      default: begin
        if (hold_i != '0) begin
          hold_next = hold_i - 1'b1;
        end else if (smooth_i > slow_lim && rung_i != '0) begin
          target    = rung_i - 1'b1;
          hold_next = cfg_i.down_hold;
        end else if (smooth_i < fast_lim && rung_i < ftrg_pkg::TopRung) begin
          target    = rung_i + 1'b1;
          hold_next = cfg_i.up_hold;
        end
      end
    endcase
  end

  assign gov_o.rung    = target;
  assign gov_o.changed = (target != rung_i);
  assign gov_o.hold    = hold_next;

endmodule

// ===== design/frame_time_resolution_governor.sv =====
// Frame-time resolution governor.
// Each request on the s_axis channel carries one frame timestamp in microseconds.
// The block smooths the frame interval and picks a rung of a five-rung resolution
// ladder (40, 50, 65, 80, 100 percent). Every request gives exactly one result on
// m_axis: rung, scale percent, a changed flag, the smoothed time and the hold count.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must
// write them only while idle, as the block itself does not enforce this. A request
// is captured in the input register when accepted; its result is then loaded into
// the result register, which drives m_axis_tvalid. Throughput is one request per
// cycle while m_axis does not stall; the whole update is a single pass through the
// smoothing multiply, threshold compares and rung step between those two registers.
// When m_axis stalls, the result register holds and the input register still takes
// one more request; after that s_axis_tready drops until the result is taken.
// Reset brings the smoothed time to 16.7 ms, the rung to full scale, the hold to
// zero, the previous timestamp to "unknown" and all registers to their defaults.
module frame_time_resolution_governor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] now_time_us
  input  logic [ftrg_pkg::InW-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] rung, [9:3] scale_percent, [10] changed, [35:11] smoothed_time,
  // [42:36] hold_left, [47:43] zero
  output logic [ftrg_pkg::OutW-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ftrg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftrg_pkg::CfgDataW-1:0] cfg_wdata_i
);

  ftrg_pkg::cfg_t               cfg_q;
  logic                         in_valid_q;
  logic [ftrg_pkg::TimeW-1:0]   in_time_q;
  logic                         out_valid_q;
  logic [ftrg_pkg::OutW-1:0]    out_data_q;
  logic [ftrg_pkg::OutW-1:0]    out_data_d;
  logic [ftrg_pkg::SmoothW-1:0] smooth_q;
  logic [ftrg_pkg::SmoothW-1:0] smooth_d;
  logic [ftrg_pkg::TimeW-1:0]   prev_q;
  logic [ftrg_pkg::RungW-1:0]   rung_q;
  logic [ftrg_pkg::HoldW-1:0]   hold_q;
  ftrg_pkg::gov_t               gov;
  logic                         advance;
  logic                         s_take;

  // The held request moves on whenever the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= ftrg_pkg::ModeAuto;
      cfg_q.slow      <= ftrg_pkg::SlowReset;
      cfg_q.fast      <= ftrg_pkg::FastReset;
      cfg_q.down_hold <= ftrg_pkg::DownHoldReset;
      cfg_q.up_hold   <= ftrg_pkg::UpHoldReset;
    end else if (cfg_we_i) begin
      case (ftrg_pkg::cfg_idx_e'(cfg_idx_i))
        ftrg_pkg::CfgMode:     cfg_q.mode      <= ftrg_pkg::mode_e'(cfg_wdata_i[1:0]);
        ftrg_pkg::CfgSlow:     cfg_q.slow      <= cfg_wdata_i;
        ftrg_pkg::CfgFast:     cfg_q.fast      <= cfg_wdata_i;
        ftrg_pkg::CfgDownHold: cfg_q.down_hold <= cfg_wdata_i[ftrg_pkg::HoldW-1:0];
        ftrg_pkg::CfgUpHold:   cfg_q.up_hold   <= cfg_wdata_i[ftrg_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_time_q <= s_axis_tdata[ftrg_pkg::TimeW-1:0];
    end
  end

  ftrg_ema u_ema (
    .now_i    (in_time_q),
    .prev_i   (prev_q),
    .smooth_i (smooth_q),
    .smooth_o (smooth_d)
  );

  ftrg_gov u_gov (
    .cfg_i    (cfg_q),
    .rung_i   (rung_q),
    .hold_i   (hold_q),
    .smooth_i (smooth_d),
    .gov_o    (gov)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= ftrg_pkg::SmoothReset;
      prev_q   <= '0;
      rung_q   <= ftrg_pkg::TopRung;
      hold_q   <= '0;
    end else if (advance) begin
      smooth_q <= smooth_d;
      prev_q   <= in_time_q;
      rung_q   <= gov.rung;
      hold_q   <= gov.hold;
    end
  end

  assign out_data_d = {5'b0, gov.hold, smooth_d, gov.changed,
                       ftrg_pkg::rung_percent(gov.rung), gov.rung};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_rung_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rung_q <= ftrg_pkg::TopRung)
    else $error("rung left the ladder");

  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cfg_q.mode == ftrg_pkg::ModeAuto && hold_q != '0)
      |=> (hold_q == $past(hold_q) - 1'b1))
    else $error("hold counter did not count down");

  a_fixed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cfg_q.mode != ftrg_pkg::ModeAuto) |=> $stable(hold_q))
    else $error("hold counter moved in a fixed mode");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (out_data_q[10] == (rung_q != $past(rung_q)))))
    else $error("changed flag disagrees with rung update");

endmodule
